>>> hdl/audio_loop_buffer_tap_top_macros.svh
// Assertion macros for the loop buffer tap RTL, used by alb_ctrl.
// Expects signals clk and rst_n in the scope of each use.
`ifndef AUDIO_LOOP_BUFFER_TAP_TOP_MACROS_SVH
`define AUDIO_LOOP_BUFFER_TAP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ALB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alb: same-cycle check failed");
`define ALB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alb: next-cycle check failed");
`else
`define ALB_ASSERT_SAME(lbl, ante, cons)
`define ALB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/alb_pkg.sv
// Shared types and constants for the loop buffer tap.
// Used by the controller, the datapath and the top level; no dependencies.
package alb_pkg;

  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MIX   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIVISOR   = 2'd2;

  typedef struct packed {
    logic load_in;
    logic clear_step;
    logic capture;
    logic mem_write;
    logic div_start;
    logic div_sel_move;
    logic tap_load;
    logic adv_step;
    logic out_load;
  } alb_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic func_writes;
    logic func_is_set;
    logic adv;
    logic move_due;
    logic div_busy;
    logic div_done;
  } alb_sts_t;

endpackage

>>> hdl/alb_rem.sv
// Iterative remainder unit, one quotient bit per cycle over a 17-bit dividend.
// Standalone; instantiated by alb_datapath.
module alb_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] rem
);

  localparam int NUM_W = 17;
  localparam logic [4:0] ITERS = 5'(NUM_W);

  logic [16:0] num_r;
  logic [16:0] den_r;
  logic [16:0] part_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [17:0] shifted;
  logic [17:0] diff;
  logic [16:0] part_nxt;

  always_comb begin
    shifted  = {part_r, num_r[16]};
    diff     = shifted - {1'b0, den_r};
    part_nxt = (shifted >= {1'b0, den_r}) ? diff[16:0] : shifted[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= dividend;
        den_r  <= divisor;
        part_r <= '0;
        cnt_r  <= ITERS;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        part_r <= part_nxt;
        num_r  <= {num_r[15:0], 1'b0};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  // The remainder is below the divisor, which never exceeds 65536.
  assign rem  = part_r[15:0];

endmodule

>>> hdl/alb_datapath.sv
// Datapath: sample memory, tap and divide counter, config registers, mix arithmetic.
// Depends on alb_pkg and alb_rem.
module alb_datapath #(
  parameter int DEPTH = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  alb_pkg::alb_cmd_t                  cmd,
  output alb_pkg::alb_sts_t                  sts,
  input  logic [alb_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [15:0]                 in_sample_in,
  input  logic signed [15:0]                 in_pre_level,
  input  logic [15:0]                        in_new_position,
  input  logic                               in_advance,
  output logic signed [15:0]                 out_read_sample,
  output logic [15:0]                        out_tap_position,
  input  logic                               cfg_wr_en,
  input  logic [alb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int LIM = (DEPTH < 65536) ? DEPTH : 65536;

  logic [16:0] loop_len_r;
  logic [15:0] step_inc_r;
  logic [15:0] rate_div_r;
  logic [15:0] dc_r;
  logic [15:0] tap_r;
  logic [AW-1:0] clr_cnt_r;

  logic [alb_pkg::FUNC_W-1:0] func_r;
  logic signed [15:0] sample_r;
  logic signed [15:0] pre_r;
  logic [15:0]        pos_r;
  logic               adv_r;

  logic signed [15:0] mem [0:DEPTH-1];
  logic signed [15:0] rd_data_r;
  logic signed [15:0] old_r;
  logic signed [31:0] prod_r;
  logic signed [15:0] out_sample_r;
  logic [15:0]        out_tap_r;

  logic [AW-1:0]      tap_addr;
  logic [AW-1:0]      mem_waddr;
  logic signed [15:0] mem_wdata;
  logic               mem_we;
  logic [16:0]        eff_len;
  logic [15:0]        div_eff;
  logic [15:0]        dc_inc;
  logic               move_due;
  logic [16:0]        dividend;
  logic               div_busy;
  logic               div_done;
  logic [15:0]        div_rem;

  logic signed [31:0] rnd;
  logic signed [31:0] rnd_sh;
  logic signed [15:0] mix_q;
  logic signed [15:0] mix_sum;
  logic signed [15:0] add_sum;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sd32767;
    else if (v < -18'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  assign tap_addr = AW'(tap_r);

  always_comb begin
    if (loop_len_r == 17'd0) eff_len = 17'd1;
    else if (loop_len_r > 17'(LIM)) eff_len = 17'(LIM);
    else eff_len = loop_len_r;
    div_eff  = (rate_div_r == 16'd0) ? 16'd1 : rate_div_r;
    dc_inc   = dc_r + 16'd1;
    move_due = (dc_inc >= div_eff);
    dividend = cmd.div_sel_move ? ({1'b0, tap_r} + {1'b0, step_inc_r}) : {1'b0, pos_r};
  end

  // Rounded Q15 product: add half an LSB, then floor through the arithmetic shift.
  always_comb begin
    rnd     = prod_r + 32'sd16384;
    rnd_sh  = rnd >>> 15;
    mix_q   = sat16(rnd_sh[17:0]);
    mix_sum = sat16({{2{mix_q[15]}}, mix_q} + {{2{sample_r[15]}}, sample_r});
    add_sum = sat16({{2{old_r[15]}}, old_r} + {{2{sample_r[15]}}, sample_r});
    case (func_r)
      alb_pkg::FUNC_MIX: mem_wdata = mix_sum;
      alb_pkg::FUNC_ADD: mem_wdata = add_sum;
      default:           mem_wdata = sample_r;
    endcase
    if (cmd.clear_step) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_waddr = tap_addr;
    end
    mem_we = cmd.clear_step | cmd.mem_write;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[tap_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_len_r <= 17'd65536;
      step_inc_r <= 16'd1;
      rate_div_r <= 16'd1;
      dc_r       <= '0;
      tap_r      <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.tap_load) tap_r <= div_rem;
      if (cmd.adv_step) dc_r <= move_due ? 16'd0 : dc_inc;
      if (cfg_wr_en) begin
        case (cfg_index)
          alb_pkg::CFG_LOOP_LENGTH:    loop_len_r <= cfg_data;
          alb_pkg::CFG_STEP_INCREMENT: step_inc_r <= cfg_data[15:0];
          alb_pkg::CFG_RATE_DIVISOR: begin
            rate_div_r <= cfg_data[15:0];
            dc_r       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_func;
      sample_r <= in_sample_in;
      pre_r    <= in_pre_level;
      pos_r    <= in_new_position;
      adv_r    <= in_advance;
    end
    if (cmd.capture) begin
      old_r  <= rd_data_r;
      prod_r <= rd_data_r * pre_r;
    end
    if (cmd.out_load) begin
      out_sample_r <= old_r;
      out_tap_r    <= tap_r;
    end
  end

  alb_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (eff_len),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    sts.clear_last  = (clr_cnt_r == AW'(LIM - 1));
    sts.func_writes = (func_r == alb_pkg::FUNC_WRITE) || (func_r == alb_pkg::FUNC_MIX) ||
                      (func_r == alb_pkg::FUNC_ADD);
    sts.func_is_set = (func_r == alb_pkg::FUNC_SET);
    sts.adv         = adv_r;
    sts.move_due    = move_due;
    sts.div_busy    = div_busy;
    sts.div_done    = div_done;
  end

  assign out_read_sample  = out_sample_r;
  assign out_tap_position = out_tap_r;

endmodule

>>> hdl/alb_ctrl.sv
// Controller state machine: memory clear, read-modify-write, tap update, output beat.
// Depends on alb_pkg and the assertion macro header.
`include "audio_loop_buffer_tap_top_macros.svh"
module alb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  alb_pkg::alb_sts_t sts_i,
  output alb_pkg::alb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_DIV,
    S_ADV,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   move_r;
  logic   move_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd_o         = '0;
    state_nxt     = state_r;
    move_nxt      = move_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_nxt     = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.mem_write = sts_i.func_writes;
        if (sts_i.func_is_set) begin
          cmd_o.div_start = 1'b1;
          move_nxt        = 1'b0;
          state_nxt       = S_DIV;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.tap_load = 1'b1;
          state_nxt      = move_r ? S_OUT : S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.div_sel_move = 1'b1;
        state_nxt          = S_OUT;
        if (sts_i.adv) begin
          cmd_o.adv_step = 1'b1;
          if (sts_i.move_due) begin
            cmd_o.div_start = 1'b1;
            move_nxt        = 1'b1;
            state_nxt       = S_DIV;
          end
        end
      end
      S_OUT: begin
        // The output register takes the beat once the previous one has left.
        if (!out_valid_r || !out_stall) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      move_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      move_r      <= move_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `ALB_ASSERT_SAME(a_div_start_idle, cmd_o.div_start, !sts_i.div_busy)
  `ALB_ASSERT_SAME(a_div_done_in_div, sts_i.div_done, state_r == S_DIV)
  `ALB_ASSERT_SAME(a_idle_div_quiet, state_r == S_IDLE, !sts_i.div_busy)
  `ALB_ASSERT_NEXT(a_load_gives_valid, cmd_o.out_load, out_valid_r)

endmodule

>>> hdl/audio_loop_buffer_tap_top.sv
// Loop buffer tap: Q15 sample memory with one moving tap.
// A new input beat is taken only after the previous item's result is in the output register;
// a set position or a tap move each run the 17-step remainder unit for the loop wrap.
// After reset the first min(DEPTH, 65536) memory entries are cleared one entry a cycle,
// during which input is stalled; configuration writes are taken throughout.
module audio_loop_buffer_tap_top #(
  parameter int DEPTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [alb_pkg::FUNC_W-1:0]     in_func,
  input  logic signed [15:0]             in_sample_in,
  input  logic signed [15:0]             in_pre_level,
  input  logic [15:0]                    in_new_position,
  input  logic                           in_advance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_read_sample,
  output logic [15:0]                    out_tap_position,
  input  logic                           cfg_wr_en,
  input  logic [alb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0] cfg_data
);

  alb_pkg::alb_cmd_t cmd;
  alb_pkg::alb_sts_t sts;

  alb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  alb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_sample_in     (in_sample_in),
    .in_pre_level     (in_pre_level),
    .in_new_position  (in_new_position),
    .in_advance       (in_advance),
    .out_read_sample  (out_read_sample),
    .out_tap_position (out_tap_position),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule

>>> tb/tb_audio_loop_buffer_tap_top.sv
// Self-checking testbench for audio_loop_buffer_tap_top: a directed table, then random beats
// under three sender and receiver idling mixes, each result checked against the table or a local predictor.
// Depends on alb_pkg and the loop buffer tap RTL; reads no files.
module tb_audio_loop_buffer_tap_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_DEPTH     = 65536;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned TAIL_CYCLES   = 60;
  localparam int unsigned ITEMS_PER_SET = 108;

  // Function codes the block treats as plain reads, and a register index it ignores.
  localparam logic [alb_pkg::FUNC_W-1:0]    FUNC_SPARE_LO  = 3'd5;
  localparam logic [alb_pkg::FUNC_W-1:0]    FUNC_SPARE_MID = 3'd6;
  localparam logic [alb_pkg::FUNC_W-1:0]    FUNC_SPARE_HI  = 3'd7;
  localparam logic [alb_pkg::CFG_IDX_W-1:0] CFG_NO_REG     = 2'd3;

  // Register settings for the random part, one column per setting.
  localparam int unsigned LOOP_SET [12] = '{65536, 1, 16, 2, 300, 65535, 0, 7, 131071, 4096,
                                            37, 5};
  localparam int unsigned STEP_SET [12] = '{1, 0, 3, 65535, 1, 250, 5, 65534, 1, 13, 4, 2};
  localparam int unsigned DIV_SET  [12] = '{1, 65535, 2, 0, 1, 3, 1, 2, 4, 1, 1, 6};

  typedef struct packed {
    logic [alb_pkg::FUNC_W-1:0] func;
    logic signed [15:0]         sample;
    logic signed [15:0]         gain;
    logic [15:0]                position;
    logic                       advance;
  } tap_beat_t;

  typedef struct packed {
    logic signed [15:0]  sample;
    logic [15:0]         position;
  } tap_result_t;

  typedef struct {
    bit                              is_cfg;
    logic [alb_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [alb_pkg::CFG_DATA_W-1:0]  reg_val;
    tap_beat_t                       beat;
    bit                              known;
    tap_result_t                     want;
  } script_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [alb_pkg::FUNC_W-1:0]       in_func;
  logic signed [15:0]               in_sample_in;
  logic signed [15:0]               in_pre_level;
  logic [15:0]                      in_new_position;
  logic                             in_advance;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [15:0]               out_read_sample;
  logic [15:0]                      out_tap_position;
  logic                             cfg_wr_en;
  logic [alb_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [alb_pkg::CFG_DATA_W-1:0]   cfg_data;

  // Predictor state: its own copy of the loop memory, tap, divider and registers.
  logic signed [15:0]      loop_mem [MEM_DEPTH];
  int unsigned             tap_pos;
  int unsigned             div_count;
  logic [16:0]             loop_reg;
  logic [15:0]             step_reg;
  logic [15:0]             div_reg;

  tap_result_t             expected_taps [$];
  script_row_t             script [$];

  int unsigned             send_idle_pct;
  int unsigned             recv_idle_pct;
  int unsigned             fail_count;
  int unsigned             beats_sent;
  int unsigned             results_checked;
  int unsigned             settings_written;
  int unsigned             tap_moves;

  audio_loop_buffer_tap_top #(
    .DEPTH(MEM_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_sample_in     (in_sample_in),
    .in_pre_level     (in_pre_level),
    .in_new_position  (in_new_position),
    .in_advance       (in_advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_sample  (out_read_sample),
    .out_tap_position (out_tap_position),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [15:0] clip_q15(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Rounded Q15 product; the arithmetic shift floors toward minus infinity.
  function automatic int q15_scale(input int a, input int b);
    int p;
    p = a * b + 16384;
    return p >>> 15;
  endfunction

  function automatic int unsigned loop_span();
    int unsigned l;
    l = loop_reg;
    if (l == 0) l = 1;
    if (l > MEM_DEPTH) l = MEM_DEPTH;
    return l;
  endfunction

  function automatic void apply_reg(input logic [alb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [alb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      alb_pkg::CFG_LOOP_LENGTH:    loop_reg = val;
      alb_pkg::CFG_STEP_INCREMENT: step_reg = val[15:0];
      alb_pkg::CFG_RATE_DIVISOR: begin
        div_reg   = val[15:0];
        div_count = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic tap_result_t predict_tap(input tap_beat_t b);
    tap_result_t         r;
    int unsigned         len;
    int unsigned         limit;
    int                  old;
    logic [15:0]         slot;
    logic signed [15:0]  scaled;
    len  = loop_span();
    slot = tap_pos[15:0];
    old  = loop_mem[slot];
    case (b.func)
      alb_pkg::FUNC_WRITE: loop_mem[slot] = b.sample;
      alb_pkg::FUNC_MIX: begin
        scaled = clip_q15(q15_scale(old, int'(b.gain)));
        loop_mem[slot] = clip_q15(int'(scaled) + int'(b.sample));
      end
      alb_pkg::FUNC_ADD: loop_mem[slot] = clip_q15(old + int'(b.sample));
      alb_pkg::FUNC_SET: tap_pos = b.position % len;
      default: ;
    endcase
    // Position set lands first, then the divided advance moves from there.
    if (b.advance) begin
      limit     = (div_reg == 16'd0) ? 1 : div_reg;
      div_count = (div_count + 1) & 32'hFFFF;
      if (div_count >= limit) begin
        div_count = 0;
        tap_pos   = (tap_pos + step_reg) % len;
        tap_moves++;
      end
    end
    r.sample   = old[15:0];
    r.position = tap_pos[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_q15();
    case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tap_beat_t random_beat();
    tap_beat_t    b;
    int unsigned  pick;
    int unsigned  len;
    pick = $urandom_range(99);
    if (pick < 15) b.func = alb_pkg::FUNC_READ;
    else if (pick < 35) b.func = alb_pkg::FUNC_WRITE;
    else if (pick < 60) b.func = alb_pkg::FUNC_MIX;
    else if (pick < 82) b.func = alb_pkg::FUNC_ADD;
    else if (pick < 94) b.func = alb_pkg::FUNC_SET;
    else begin
      case ($urandom_range(2))
        0:       b.func = FUNC_SPARE_LO;
        1:       b.func = FUNC_SPARE_MID;
        default: b.func = FUNC_SPARE_HI;
      endcase
    end
    b.sample = pick_q15();
    b.gain   = pick_q15();
    len      = loop_span();
    // Positions often sit at the loop boundary so the modulo gets exercised.
    case ($urandom_range(7))
      0:       b.position = 16'(len);
      1:       b.position = 16'(len - 1);
      2:       b.position = 16'($urandom_range(len - 1));
      default: b.position = 16'($urandom);
    endcase
    b.advance = 1'($urandom_range(1));
    return b;
  endfunction

  function automatic script_row_t beat_row(input logic [alb_pkg::FUNC_W-1:0] f,
                                           input logic signed [15:0] s,
                                           input logic signed [15:0] g,
                                           input logic [15:0] p,
                                           input logic adv,
                                           input bit known,
                                           input logic signed [15:0] want_sample,
                                           input logic [15:0] want_position);
    script_row_t row;
    row.is_cfg        = 1'b0;
    row.reg_idx       = alb_pkg::CFG_LOOP_LENGTH;
    row.reg_val       = '0;
    row.beat          = '{func: f, sample: s, gain: g, position: p, advance: adv};
    row.known         = known;
    row.want.sample   = want_sample;
    row.want.position = want_position;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [alb_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [alb_pkg::CFG_DATA_W-1:0] val);
    script_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.beat    = '0;
    row.known   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  task automatic send_beat(input tap_beat_t b, input bit known, input tap_result_t want);
    tap_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_func         <= b.func;
    in_sample_in    <= b.sample;
    in_pre_level    <= b.gain;
    in_new_position <= b.position;
    in_advance      <= b.advance;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_tap(b);
    expected_taps.push_back(known ? want : predicted);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [alb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [alb_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
    settings_written++;
  endtask

  // Registers change only once every result is back and the block takes input again.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_taps.size() != 0) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tap_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_taps.size() == 0) begin
        $error("result beat with nothing expected: read_sample %0d tap_position %0d",
               out_read_sample, out_tap_position);
        fail_count++;
      end else begin
        want = expected_taps.pop_front();
        results_checked++;
        if (out_read_sample !== want.sample) begin
          $error("read_sample: expected %0d, got %0d", want.sample, out_read_sample);
          fail_count++;
        end
        if (out_tap_position !== want.position) begin
          $error("tap_position: expected %0d, got %0d", want.position, out_tap_position);
          fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run timed out after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, expected_taps.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tap_result_t no_want;
    int unsigned set_no;
    no_want = '0;
    foreach (loop_mem[i]) loop_mem[i] = 16'sh0000;
    tap_pos       = 0;
    div_count     = 0;
    loop_reg      = 17'd65536;
    step_reg      = 16'd1;
    div_reg       = 16'd1;
    send_idle_pct = 10;
    recv_idle_pct = 77;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= alb_pkg::FUNC_READ;
    in_sample_in    <= 16'sh0000;
    in_pre_level    <= 16'sh0000;
    in_new_position <= 16'd0;
    in_advance      <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= alb_pkg::CFG_LOOP_LENGTH;
    cfg_data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. The first rows run on the power-up state: memory cleared, tap at zero.
    script.push_back(beat_row(alb_pkg::FUNC_READ,  16'sh0000, 16'sh0000, 16'd0, 1'b0,
                              1'b1, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_WRITE, 16'sh7FFF, 16'sh0000, 16'd0, 1'b0,
                              1'b1, 16'sh0000, 16'd0));
    // Adding to full scale clips at the top, and below at the bottom.
    script.push_back(beat_row(alb_pkg::FUNC_ADD,   16'sh0001, 16'sh0000, 16'd0, 1'b0,
                              1'b1, 16'sh7FFF, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_WRITE, 16'sh8000, 16'sh0000, 16'd0, 1'b0,
                              1'b1, 16'sh7FFF, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_ADD,   16'shFFFF, 16'sh0000, 16'd0, 1'b0,
                              1'b1, 16'sh8000, 16'd0));
    // Negative full scale squared overflows the Q15 product.
    script.push_back(beat_row(alb_pkg::FUNC_MIX,   16'sh0000, 16'sh8000, 16'd0, 1'b0,
                              1'b1, 16'sh8000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_MIX,   16'sh7FFF, 16'sh7FFF, 16'd0, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    // A tiny negative product rounds down to minus one rather than to zero.
    script.push_back(beat_row(alb_pkg::FUNC_MIX,   16'sh0000, 16'shFFFF, 16'd0, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_READ,  16'sh0000, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_WRITE, 16'sh5555, 16'shAAAA, 16'hAAAA, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'hFFFF, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    // Unused codes only read; the advance from the last entry wraps to zero.
    script.push_back(beat_row(FUNC_SPARE_LO, 16'sh0000, 16'sh0000, 16'd0, 1'b1,
                              1'b1, 16'sh0000, 16'd0));
    script.push_back(beat_row(FUNC_SPARE_MID, 16'sh7FFF, 16'sh7FFF, 16'd0, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(FUNC_SPARE_HI, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b0,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'hFFFF, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(cfg_row(alb_pkg::CFG_LOOP_LENGTH, 17'd10));
    // A position equal to the loop length lands on zero.
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'd10, 1'b0,
                              1'b1, 16'shFFFF, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'hFFFF, 1'b0,
                              1'b1, 16'shFFFF, 16'd5));
    script.push_back(cfg_row(alb_pkg::CFG_STEP_INCREMENT, 17'd65535));
    script.push_back(beat_row(alb_pkg::FUNC_READ,  16'sh0000, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    // A zero loop length behaves as a single entry.
    script.push_back(cfg_row(alb_pkg::CFG_LOOP_LENGTH, 17'd0));
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'd12345, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(cfg_row(alb_pkg::CFG_LOOP_LENGTH, 17'd65536));
    script.push_back(cfg_row(alb_pkg::CFG_STEP_INCREMENT, 17'd7));
    script.push_back(cfg_row(alb_pkg::CFG_RATE_DIVISOR, 17'd3));
    script.push_back(beat_row(alb_pkg::FUNC_SET,   16'sh0000, 16'sh0000, 16'd50000, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    // Shrinking the loop under the tap leaves it in place until the next move.
    script.push_back(cfg_row(alb_pkg::CFG_LOOP_LENGTH, 17'd100));
    script.push_back(beat_row(alb_pkg::FUNC_READ,  16'sh0000, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_WRITE, 16'sd1234, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    // A zero divisor moves on every advance.
    script.push_back(cfg_row(alb_pkg::CFG_RATE_DIVISOR, 17'd0));
    script.push_back(beat_row(alb_pkg::FUNC_ADD,   16'sd100, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(cfg_row(CFG_NO_REG, 17'h1FFFF));
    script.push_back(cfg_row(alb_pkg::CFG_LOOP_LENGTH, 17'h1FFFF));
    script.push_back(cfg_row(alb_pkg::CFG_STEP_INCREMENT, 17'h10002));
    script.push_back(cfg_row(alb_pkg::CFG_RATE_DIVISOR, 17'd65535));
    script.push_back(beat_row(alb_pkg::FUNC_READ,  16'sh0000, 16'sh0000, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));
    script.push_back(beat_row(alb_pkg::FUNC_MIX,   16'sh8000, 16'sh7FFF, 16'd0, 1'b1,
                              1'b0, 16'sh0000, 16'd0));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (i == 0 || !script[i-1].is_cfg) drain_results();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        cfg_wr_en <= 1'b0;
        send_beat(script[i].beat, script[i].known, script[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        set_no = ph * 4 + s;
        drain_results();
        write_reg(alb_pkg::CFG_LOOP_LENGTH, 17'(LOOP_SET[set_no]));
        write_reg(alb_pkg::CFG_STEP_INCREMENT, 17'(STEP_SET[set_no]));
        write_reg(alb_pkg::CFG_RATE_DIVISOR, 17'(DIV_SET[set_no]));
        cfg_wr_en <= 1'b0;
        for (int n = 0; n < ITEMS_PER_SET; n++) send_beat(random_beat(), 1'b0, no_want);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d beats (directed table of %0d rows) and checked %0d results.",
             beats_sent, script.size(), results_checked);
    $display("The run went through %0d register writes and %0d tap moves; %0d mismatches.",
             settings_written, tap_moves, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/alb_pkg.sv
hdl/alb_rem.sv
hdl/alb_datapath.sv
hdl/alb_ctrl.sv
hdl/audio_loop_buffer_tap_top.sv
tb/tb_audio_loop_buffer_tap_top.sv
